// File: rtl/core/lmrb_pkg.sv
// ============================================================================
// lmrb_pkg
// Shared constants, codes, types and helpers of the length-tagged message
// ring buffer.
// ============================================================================
package lmrb_pkg;

  // Buffer geometry.
  localparam int DEPTH     = 1024;
  localparam int TAG_BYTES = 2;

  // Derived widths.
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int USED_W = $clog2(DEPTH + 1);
  localparam int SUM_W  = USED_W + 1;
  localparam int TAG_W  = 8 * TAG_BYTES;
  localparam int CNT_W  = (TAG_BYTES > 1) ? $clog2(TAG_BYTES) : 1;

  // Fixed field widths.
  localparam int MODE_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_WRITE_RAW = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE_TAG = 3'd1;
  localparam logic [MODE_W-1:0] MODE_READ_RAW  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ_MSG  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_STATUS    = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NO_MSG    = 2'd3;

  // Sequencer states.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_TAGW = 6'b000010,
    S_PUT  = 6'b000100,
    S_FILL = 6'b001000,
    S_WAIT = 6'b010000,
    S_DONE = 6'b100000
  } lmrb_state_t;

  // Memory write request.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } lmrb_wr_t;

  // Fill state seen by the status unit.
  typedef struct packed {
    logic [USED_W-1:0] used;
    logic [TAG_W-1:0]  tag;
  } lmrb_view_t;

  // Status fields reported with every result.
  typedef struct packed {
    logic [COUNT_W-1:0] used_bytes;
    logic [COUNT_W-1:0] free_bytes;
    logic [LEN_W-1:0]   front_length;
    logic [LEN_W-1:0]   front_available;
    logic               has_message;
  } lmrb_report_t;

  // Circular address: base plus offset, folded once into the store.
  function automatic logic [ADDR_W-1:0] wrap_add(logic [ADDR_W-1:0] base,
                                                 logic [USED_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  // Byte idx of a length tag; bytes above the 16-bit length are zero.
  function automatic logic [BYTE_W-1:0] tag_byte(logic [LEN_W-1:0] len,
                                                 logic [CNT_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(len) >> (8 * idx);
    return wide[BYTE_W-1:0];
  endfunction

endpackage

// File: rtl/core/lmrb_if.sv
// ============================================================================
// lmrb_if
// Valid/ready channels of the ring buffer: request items in, results out.
// ============================================================================
interface lmrb_in_if
  import lmrb_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [BYTE_W-1:0] data_byte;
  logic [LEN_W-1:0]  message_length;

  modport source (output valid, output mode, output data_byte,
                  output message_length, input ready);
  modport sink   (input valid, input mode, input data_byte,
                  input message_length, output ready);
endinterface

interface lmrb_out_if
  import lmrb_pkg::*;
  ;
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   read_byte;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  used_bytes;
  logic [COUNT_W-1:0]  free_bytes;
  logic [LEN_W-1:0]    front_length;
  logic [LEN_W-1:0]    front_available;
  logic                has_message;

  modport source (output valid, output read_byte, output status,
                  output used_bytes, output free_bytes, output front_length,
                  output front_available, output has_message, input ready);
  modport sink   (input valid, input read_byte, input status,
                  input used_bytes, input free_bytes, input front_length,
                  input front_available, input has_message, output ready);
endinterface

// File: rtl/core/lmrb_ram.sv
// ============================================================================
// lmrb_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ============================================================================
module lmrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and a registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/lmrb_stat.sv
// ============================================================================
// lmrb_stat
// Status unit: derives the fill counts, the saturated front tag and the
// available length from the held count and the cached front tag.
// ============================================================================
module lmrb_stat
  import lmrb_pkg::*;
(
  input  lmrb_view_t   view,
  output lmrb_report_t report
);

  logic [31:0] used32;
  logic [31:0] tag32;
  logic [31:0] room32;
  logic [31:0] avail32;
  logic [31:0] free32;
  logic        held;

  // Clamp a wide value to the 16-bit length field.
  function automatic logic [LEN_W-1:0] sat_len(logic [31:0] v);
    return (v > 32'h0000_FFFF) ? {LEN_W{1'b1}} : v[LEN_W-1:0];
  endfunction

  // Room behind the tag and the tag limited to it.
  assign used32  = 32'(view.used);
  assign tag32   = 32'(view.tag);
  assign free32  = 32'(DEPTH) - used32;
  assign held    = used32 >= 32'(TAG_BYTES);
  assign room32  = used32 - 32'(TAG_BYTES);
  assign avail32 = (tag32 > room32) ? room32 : tag32;

  // Report fields; the tag fields read as zero without a whole tag held.
  assign report.used_bytes      = used32[COUNT_W-1:0];
  assign report.free_bytes      = free32[COUNT_W-1:0];
  assign report.front_length    = held ? sat_len(tag32) : '0;
  assign report.front_available = held ? sat_len(avail32) : '0;
  assign report.has_message     = used32 > 32'(TAG_BYTES);

endmodule

// File: rtl/core/lmrb_ctrl.sv
// ============================================================================
// lmrb_ctrl
// Sequencer of the ring buffer: decodes each request, keeps the front
// pointer, the held count and a cached copy of the front tag bytes, drives
// the byte store and holds the result register.
// ============================================================================
module lmrb_ctrl
  import lmrb_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  lmrb_in_if.sink       cmd,
  lmrb_out_if.source    rsp,
  output lmrb_wr_t      wr,
  output logic [ADDR_W-1:0] raddr,
  input  logic [BYTE_W-1:0] rdata,
  output lmrb_view_t    view,
  input  lmrb_report_t  report
);

  lmrb_state_t                    state;
  logic [CNT_W-1:0]               cnt;
  logic [ADDR_W-1:0]              front;
  logic [USED_W-1:0]              used;
  logic [TAG_BYTES-1:0][BYTE_W-1:0] win;
  logic [TAG_W-1:0]               tag;
  logic [LEN_W-1:0]               mlen_r;
  logic [STATUS_W-1:0]            stat_r;
  logic [BYTE_W-1:0]              rd_r;
  logic                           pend_valid;
  logic                           pend_rd;
  logic [CNT_W-1:0]               pend_slot;
  logic                           rsp_valid;
  lmrb_report_t                   rsp_report;
  logic [BYTE_W-1:0]              rsp_byte;
  logic [STATUS_W-1:0]            rsp_status;

  logic             accept;
  logic             ok_write;
  logic             ok_tag;
  logic             ok_rraw;
  logic             ok_rmsg;
  logic             tag_gt1;
  logic             low_slot;
  logic [CNT_W-1:0] slot_idx;
  logic             last_cnt;

  // Handshake and decode conditions.
  assign accept   = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);
  assign tag      = win;
  assign ok_write = 32'(used) < 32'(DEPTH);
  assign ok_tag   = (32'(DEPTH) - 32'(used)) >= 32'(TAG_BYTES);
  assign ok_rraw  = used != '0;
  assign ok_rmsg  = 32'(used) > 32'(TAG_BYTES);
  assign tag_gt1  = 32'(tag) > 32'd1;
  assign low_slot = 32'(used) < 32'(TAG_BYTES);
  assign slot_idx = used[CNT_W-1:0];
  assign last_cnt = cnt == CNT_W'(TAG_BYTES - 1);

  assign view.used = used;
  assign view.tag  = tag;

  // Store write port: raw byte, tag bytes at the back, or tag rewrite.
  always_comb begin
    wr.we   = 1'b0;
    wr.addr = wrap_add(front, used);
    wr.data = cmd.data_byte;
    priority if (state == S_IDLE && accept && cmd.mode == MODE_WRITE_RAW
                 && ok_write) begin
      wr.we = 1'b1;
    end else if (state == S_TAGW) begin
      wr.we   = 1'b1;
      wr.data = tag_byte(mlen_r, cnt);
    end else if (state == S_PUT) begin
      wr.we   = 1'b1;
      wr.addr = wrap_add(front, USED_W'(cnt));
      wr.data = win[cnt];
    end else begin
      wr.we = 1'b0;
    end
  end

  // Store read port: byte behind the tag, or refetch of the front window.
  assign raddr = (state == S_FILL) ? wrap_add(front, USED_W'(cnt))
                                   : wrap_add(front, USED_W'(TAG_BYTES));

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      front      <= '0;
      used       <= '0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      // Land the read issued in the previous cycle.
      pend_valid <= 1'b0;
      if (pend_valid) begin
        if (pend_rd) begin
          rd_r <= rdata;
        end else begin
          win[pend_slot] <= rdata;
        end
      end

      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            mlen_r <= cmd.message_length;
            rd_r   <= '0;
            stat_r <= STAT_OK;
            cnt    <= '0;
            state  <= S_DONE;
            unique case (cmd.mode)
              MODE_WRITE_RAW: begin
                if (ok_write) begin
                  used <= used + USED_W'(1);
                  if (low_slot) begin
                    win[slot_idx] <= cmd.data_byte;
                  end
                end else begin
                  stat_r <= STAT_OVERFLOW;
                end
              end
              MODE_WRITE_TAG: begin
                if (ok_tag) begin
                  state <= S_TAGW;
                end else begin
                  stat_r <= STAT_OVERFLOW;
                end
              end
              MODE_READ_RAW: begin
                if (ok_rraw) begin
                  rd_r  <= win[0];
                  for (int i = 0; i < TAG_BYTES - 1; i++) begin
                    win[i] <= win[i+1];
                  end
                  front      <= wrap_add(front, USED_W'(1));
                  used       <= used - USED_W'(1);
                  pend_valid <= 1'b1;
                  pend_rd    <= 1'b0;
                  pend_slot  <= CNT_W'(TAG_BYTES - 1);
                  state      <= S_WAIT;
                end else begin
                  stat_r <= STAT_UNDERFLOW;
                end
              end
              MODE_READ_MSG: begin
                if (ok_rmsg) begin
                  pend_valid <= 1'b1;
                  pend_rd    <= 1'b1;
                  if (tag_gt1) begin
                    // Tag moves up one byte and counts down.
                    front <= wrap_add(front, USED_W'(1));
                    used  <= used - USED_W'(1);
                    win   <= tag - TAG_W'(1);
                    state <= S_PUT;
                  end else begin
                    // Last byte: drop it together with its tag.
                    front <= wrap_add(front, USED_W'(TAG_BYTES + 1));
                    used  <= used - USED_W'(TAG_BYTES + 1);
                    state <= S_FILL;
                  end
                end else begin
                  stat_r <= STAT_NO_MSG;
                end
              end
              MODE_CLEAR: begin
                front <= '0;
                used  <= '0;
              end
              MODE_STATUS: begin
                state <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_TAGW: begin
          used <= used + USED_W'(1);
          if (low_slot) begin
            win[slot_idx] <= tag_byte(mlen_r, cnt);
          end
          cnt <= cnt + CNT_W'(1);
          if (last_cnt) begin
            state <= S_DONE;
          end
        end
        S_PUT: begin
          cnt <= cnt + CNT_W'(1);
          if (last_cnt) begin
            state <= S_DONE;
          end
        end
        S_FILL: begin
          pend_valid <= 1'b1;
          pend_rd    <= 1'b0;
          pend_slot  <= cnt;
          cnt        <= cnt + CNT_W'(1);
          if (last_cnt) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_byte   <= rd_r;
            rsp_status <= stat_r;
            rsp_report <= report;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register onto the channel.
  assign rsp.valid           = rsp_valid;
  assign rsp.read_byte       = rsp_byte;
  assign rsp.status          = rsp_status;
  assign rsp.used_bytes      = rsp_report.used_bytes;
  assign rsp.free_bytes      = rsp_report.free_bytes;
  assign rsp.front_length    = rsp_report.front_length;
  assign rsp.front_available = rsp_report.front_available;
  assign rsp.has_message     = rsp_report.has_message;

`ifndef ASSERT_OFF
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    32'(used) <= 32'(DEPTH))
    else $error("held count beyond store depth");

  a_front_bound: assert property (@(posedge clk) disable iff (rst)
    32'(front) < 32'(DEPTH))
    else $error("front pointer outside the store");

  a_pend_state: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == S_FILL || state == S_WAIT || state == S_PUT))
    else $error("read data landing outside a read sequence");

  a_we_state: assert property (@(posedge clk) disable iff (rst)
    wr.we |-> (state == S_IDLE || state == S_TAGW || state == S_PUT))
    else $error("store write outside a write step");

  a_rsp_load: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_DONE))
    else $error("result raised without a finished request");
`endif

endmodule

// File: rtl/core/length_tagged_message_ring_buffer.sv
// ============================================================================
// length_tagged_message_ring_buffer
// Byte ring buffer holding messages behind little-endian length tags, with
// raw and message reads, clear and a status report on every request.
//
//   Channel | Dir | Moves                                     | Handshake
//   --------+-----+-------------------------------------------+-----------
//   cmd     | in  | mode, data_byte, message_length           | valid/ready
//   rsp     | out | read_byte, status, used/free_bytes,       | valid/ready
//           |     | front_length, front_available, has_message|
//
// Steps per request: a raw write, a clear, a status or a refused request
// goes straight to the result register; a raw read first lands one store
// read that refills the cached front tag; a tag write and a message read
// that keeps its tag pass each tag byte through the write port in turn;
// the read of a message's last byte refetches the next front tag through
// the read port before its result.
// Reset clears the front pointer and the held count; the byte store needs
// no clearing pass, since bytes that are not held never reach a result.
// A result waits in the output register while the next request is taken;
// a request finishes only once that register is free again.
// ============================================================================
module length_tagged_message_ring_buffer
  import lmrb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  lmrb_in_if.sink    cmd,
  lmrb_out_if.source rsp
);

  lmrb_wr_t          wr;
  logic [ADDR_W-1:0] raddr;
  logic [BYTE_W-1:0] rdata;
  lmrb_view_t        view;
  lmrb_report_t      report;

  // Request sequencer and result register.
  lmrb_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .rsp    (rsp),
    .wr     (wr),
    .raddr  (raddr),
    .rdata  (rdata),
    .view   (view),
    .report (report)
  );

  // Byte store.
  lmrb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Fill and front tag report.
  lmrb_stat u_stat (
    .view   (view),
    .report (report)
  );

endmodule

// File: bench/lmrb_checker.sv
// ============================================================================
// lmrb_checker
// Result checker for the length-tagged message ring buffer. It watches the
// request and result channels, keeps its own copy of the byte store, the
// front pointer and the held count, works out the result of every accepted
// request, and compares each accepted result with the oldest one awaited.
// ============================================================================
module lmrb_checker
  import lmrb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  lmrb_in_if   cmd,
  lmrb_out_if  rsp,
  output int   mismatch_count,
  output int   awaited_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned wide_t;

  // One result as it appears on the result channel.
  typedef struct packed {
    logic [BYTE_W-1:0]   read_byte;
    logic [STATUS_W-1:0] status;
    lmrb_report_t        report;
  } ring_result_t;

  logic [BYTE_W-1:0] shadow_store [DEPTH];
  int unsigned       shadow_front;
  int unsigned       shadow_used;
  ring_result_t      awaited_results [$];

  // Store index of the byte at a distance from the oldest one.
  function automatic int unsigned ring_slot(int unsigned off);
    return (shadow_front + off) % DEPTH;
  endfunction

  // Little-endian tag held in the first TAG_BYTES bytes.
  function automatic wide_t front_tag();
    wide_t v;
    int    i;
    v = 0;
    for (i = 0; i < TAG_BYTES; i++) begin
      v |= wide_t'(shadow_store[ring_slot(i)]) << (8 * i);
    end
    return v;
  endfunction

  function automatic void push_byte(logic [BYTE_W-1:0] b);
    shadow_store[ring_slot(shadow_used)] = b;
    shadow_used++;
  endfunction

  function automatic void drop_bytes(int unsigned n);
    shadow_front = ring_slot(n);
    shadow_used -= n;
  endfunction

  function automatic void store_front_tag(wide_t v);
    int i;
    for (i = 0; i < TAG_BYTES; i++) begin
      shadow_store[ring_slot(i)] = BYTE_W'(v >> (8 * i));
    end
  endfunction

  // Applies one request to the shadow state and returns its result.
  function automatic ring_result_t apply_request(logic [MODE_W-1:0] mode,
                                                 logic [BYTE_W-1:0] data,
                                                 logic [LEN_W-1:0]  len);
    ring_result_t r;
    wide_t        tag;
    wide_t        room;
    wide_t        avail;
    int           i;
    r = '0;
    case (mode)
      MODE_WRITE_RAW: begin
        if (shadow_used >= DEPTH) begin
          r.status = STAT_OVERFLOW;
        end else begin
          push_byte(data);
        end
      end
      MODE_WRITE_TAG: begin
        if (DEPTH - shadow_used < TAG_BYTES) begin
          r.status = STAT_OVERFLOW;
        end else begin
          for (i = 0; i < TAG_BYTES; i++) begin
            push_byte(BYTE_W'(wide_t'(len) >> (8 * i)));
          end
        end
      end
      MODE_READ_RAW: begin
        if (shadow_used == 0) begin
          r.status = STAT_UNDERFLOW;
        end else begin
          r.read_byte = shadow_store[shadow_front];
          drop_bytes(1);
        end
      end
      MODE_READ_MSG: begin
        if (shadow_used <= TAG_BYTES) begin
          r.status = STAT_NO_MSG;
        end else begin
          tag         = front_tag();
          r.read_byte = shadow_store[ring_slot(TAG_BYTES)];
          // A tag above one slides forward over the byte just taken.
          if (tag > 1) begin
            drop_bytes(1);
            store_front_tag(tag - 1);
          end else begin
            drop_bytes(1 + TAG_BYTES);
          end
        end
      end
      MODE_CLEAR: begin
        shadow_used  = 0;
        shadow_front = 0;
      end
      default: begin
      end
    endcase

    // Fill report after the operation.
    r.report.used_bytes  = COUNT_W'(shadow_used);
    r.report.free_bytes  = COUNT_W'(DEPTH - shadow_used);
    r.report.has_message = (shadow_used > TAG_BYTES);
    if (shadow_used >= TAG_BYTES) begin
      tag   = front_tag();
      room  = shadow_used - TAG_BYTES;
      avail = (tag > room) ? room : tag;
      r.report.front_length    = (tag > 16'hFFFF) ? 16'hFFFF : LEN_W'(tag);
      r.report.front_available = (avail > 16'hFFFF) ? 16'hFFFF : LEN_W'(avail);
    end
    return r;
  endfunction

  function automatic void show(string label, ring_result_t r);
    $display("%s byte=%02h status=%0d used=%0d free=%0d len=%0d avail=%0d msg=%0b",
             label, r.read_byte, r.status, r.report.used_bytes,
             r.report.free_bytes, r.report.front_length,
             r.report.front_available, r.report.has_message);
  endfunction

  // Record each accepted request and check each accepted result.
  always @(posedge clk) begin : watch
    ring_result_t got;
    ring_result_t want;
    if (rst) begin
      awaited_results.delete();
      shadow_front = 0;
      shadow_used  = 0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        awaited_results.push_back(apply_request(cmd.mode, cmd.data_byte,
                                                cmd.message_length));
      end
      if (rsp.valid && rsp.ready) begin
        got = {rsp.read_byte, rsp.status, rsp.used_bytes, rsp.free_bytes,
               rsp.front_length, rsp.front_available, rsp.has_message};
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            show("result with no request pending:", got);
          end
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              show("result mismatch, expected:", want);
              show("                   actual:", got);
            end
          end
        end
      end
    end
    awaited_count = awaited_results.size();
  end

endmodule

// File: bench/tb_top.sv
// ============================================================================
// tb_top
// Top level of the ring buffer testbench. It drives requests with random
// gaps and a randomly stalling result sink: a directed opening over the
// edge cases, random message traffic, a fill to overflow from a shifted
// front pointer, a drain towards the end of the store, and a final stretch
// across its boundary at full rate. The checker beside the block judges every result.
// ============================================================================
module tb_top
  import lmrb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;
  bit   quiet;
  int   items_sent;
  int   stall_left;
  int   mismatch_count;
  int   awaited_count;

  lmrb_in_if  cmd ();
  lmrb_out_if rsp ();

  length_tagged_message_ring_buffer u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  lmrb_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .rsp            (rsp),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #3ms;
    $display("length_tagged_message_ring_buffer verification failed");
    $finish;
  end

  // No idling at the end of the run, nor in every fourth window of requests.
  function automatic bit calm();
    return quiet || ((items_sent / 64) % 4 == 3);
  endfunction

  // Result sink: ready drops in short random bursts.
  initial begin
    rsp.ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (calm()) begin
        rsp.ready <= 1'b1;
      end else if (stall_left > 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 4) == 0) begin
        rsp.ready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  task automatic hold_off(int n);
    repeat (n) begin
      @(negedge clk);
      cmd.valid <= 1'b0;
    end
  endtask

  // Presents one request and waits until it is taken.
  task automatic issue(logic [MODE_W-1:0] mode, logic [BYTE_W-1:0] data,
                       logic [LEN_W-1:0] len);
    if (!calm() && $urandom_range(0, 3) == 0) begin
      hold_off($urandom_range(1, 3));
    end
    @(negedge clk);
    cmd.valid          <= 1'b1;
    cmd.mode           <= mode;
    cmd.data_byte      <= data;
    cmd.message_length <= len;
    do @(posedge clk); while (!cmd.ready);
    items_sent++;
  endtask

  // A tag, its body (now and then one byte longer), then message reads.
  task automatic message_burst();
    int len;
    int body;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                      : $urandom_range(0, 6);
    issue(MODE_WRITE_TAG, BYTE_W'($urandom_range(0, 255)), LEN_W'(len));
    body = (len <= 6) ? len : $urandom_range(1, 6);
    if ($urandom_range(0, 5) == 0) begin
      body++;
    end
    repeat (body) issue(MODE_WRITE_RAW, BYTE_W'($urandom_range(0, 255)),
                        LEN_W'($urandom_range(0, 65535)));
    repeat (body + $urandom_range(0, 1)) begin
      issue(MODE_READ_MSG, BYTE_W'($urandom_range(0, 255)),
            LEN_W'($urandom_range(0, 65535)));
    end
  endtask

  // Mostly well-formed messages, with noise, raw reads and rare clears.
  task automatic random_mix(int stop_at);
    int pick;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 15);
      if (pick < 10) begin
        message_burst();
      end else if (pick < 13) begin
        issue(MODE_W'($urandom_range(0, 7)), BYTE_W'($urandom_range(0, 255)),
              LEN_W'($urandom_range(0, 65535)));
      end else if (pick < 15) begin
        repeat ($urandom_range(1, 3)) issue(MODE_READ_RAW,
                                            BYTE_W'($urandom_range(0, 255)),
                                            LEN_W'($urandom_range(0, 65535)));
      end else begin
        issue(($urandom_range(0, 3) == 0) ? MODE_CLEAR : MODE_STATUS,
              BYTE_W'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    rst                = 1'b1;
    quiet              = 1'b0;
    items_sent         = 0;
    cmd.valid          = 1'b0;
    cmd.mode           = MODE_STATUS;
    cmd.data_byte      = '0;
    cmd.message_length = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty store: status, raw underflow, message read with nothing held.
    issue(MODE_STATUS,    8'h00, 16'h0000);
    issue(MODE_READ_RAW,  8'h00, 16'h0000);
    issue(MODE_READ_MSG,  8'h00, 16'h0000);
    // A lone tag is not yet a message; a zero tag goes with its first byte.
    issue(MODE_WRITE_TAG, 8'h00, 16'h0000);
    issue(MODE_STATUS,    8'h00, 16'h0000);
    issue(MODE_READ_MSG,  8'h00, 16'h0000);
    issue(MODE_WRITE_RAW, 8'hFF, 16'h0000);
    issue(MODE_READ_MSG,  8'h00, 16'h0000);
    // Tag of one is discarded after one byte; the next byte stays raw.
    issue(MODE_WRITE_TAG, 8'h00, 16'h0001);
    issue(MODE_WRITE_RAW, 8'h00, 16'h0000);
    issue(MODE_WRITE_RAW, 8'hA5, 16'h0000);
    issue(MODE_READ_MSG,  8'h00, 16'h0000);
    issue(MODE_READ_RAW,  8'h00, 16'h0000);
    // Largest tag: available length is limited to the bytes held.
    issue(MODE_WRITE_TAG, 8'h00, 16'hFFFF);
    issue(MODE_WRITE_RAW, 8'h5A, 16'h0000);
    issue(MODE_READ_MSG,  8'h00, 16'h0000);
    issue(MODE_READ_RAW,  8'h00, 16'h0000);
    // Unused mode codes act as status only.
    issue(3'd6, 8'hFF, 16'hFFFF);
    issue(3'd7, 8'h00, 16'h5555);
    // Tag above one slides forward and counts down.
    issue(MODE_WRITE_TAG, 8'h00, 16'h0003);
    issue(MODE_WRITE_RAW, 8'h11, 16'h0000);
    issue(MODE_WRITE_RAW, 8'h22, 16'h0000);
    issue(MODE_READ_MSG,  8'h00, 16'h0000);
    issue(MODE_CLEAR,     8'h00, 16'h0000);
    issue(MODE_READ_RAW,  8'h00, 16'h0000);

    random_mix(150);

    // Let every result out before the fill.
    hold_off(1);
    wait (awaited_count == 0);

    // Shift the front pointer so that the fill wraps around the store.
    issue(MODE_CLEAR, 8'h00, 16'h0000);
    repeat (4) issue(MODE_WRITE_RAW, BYTE_W'($urandom_range(0, 255)), 16'h0000);
    repeat (4) issue(MODE_READ_RAW, 8'h00, 16'h0000);

    // Fill with zero tags up to two free bytes, then hit both overflows.
    repeat (DEPTH / TAG_BYTES - 1) issue(MODE_WRITE_TAG,
                                         BYTE_W'($urandom_range(0, 255)),
                                         16'h0000);
    issue(MODE_WRITE_RAW, 8'h00, 16'h0000);
    issue(MODE_WRITE_TAG, 8'h00, LEN_W'($urandom_range(0, 65535)));
    issue(MODE_WRITE_RAW, BYTE_W'($urandom_range(0, 255)), 16'h0000);
    issue(MODE_WRITE_RAW, BYTE_W'($urandom_range(0, 255)), 16'h0000);
    issue(MODE_WRITE_TAG, 8'h00, LEN_W'($urandom_range(0, 65535)));

    // Drain most of it, so the front nears the end of the store.
    repeat (333) issue(MODE_READ_MSG, BYTE_W'($urandom_range(0, 255)),
                       LEN_W'($urandom_range(0, 65535)));

    // Final stretch across the store boundary, at full rate.
    quiet = 1'b1;
    random_mix(items_sent + 40);

    hold_off(1);
    wait (awaited_count == 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("length_tagged_message_ring_buffer verification clean");
    end else begin
      $display("length_tagged_message_ring_buffer verification failed");
    end
    $finish;
  end

endmodule
